// ===== rtl/bstt_pkg.sv =====
// ----------------------------------------------------------------------------
// bstt_pkg
// Shared types and constants of the bounded slot tracking table.
// ----------------------------------------------------------------------------
`default_nettype none

package bstt_pkg;

  localparam int TABLE_ENTRIES = 64;

  localparam logic [2:0] OP_SET   = 3'd0;
  localparam logic [2:0] OP_ERASE = 3'd1;
  localparam logic [2:0] OP_COPY  = 3'd2;
  localparam logic [2:0] OP_INVAL = 3'd3;
  localparam logic [2:0] OP_FIND  = 3'd4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] key_owner;
    logic [31:0] key_rest;
    logic [31:0] src_owner;
    logic [31:0] src_rest;
    logic [63:0] content_handle;
    logic [31:0] content_payload;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        hit;
    logic [63:0] hit_handle;
    logic [31:0] hit_payload;
  } out_item_t;

  typedef struct packed {
    logic [63:0] handle;
    logic [31:0] payload;
  } content_t;

  typedef struct packed {
    logic        look;
    logic        wr_dst;
    logic        ins;
    logic        clr_dst;
    logic        clr_inv;
    logic [31:0] owner;
    logic [31:0] rest;
    logic [31:0] src_owner;
    logic [31:0] src_rest;
    logic [63:0] handle;
    logic [31:0] payload;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/bounded_slot_tracking_table.sv =====
// ----------------------------------------------------------------------------
// bounded_slot_tracking_table
// Capacity-limited associative table built as a row of entry cells.
// Sequence: an accepted item passes the look and execute states, then its
// result is held valid until taken. Only one item is in flight: a new item
// is accepted only after the result of the last one has been handed off.
// Reset: synchronous active-low; all entries invalid, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_slot_tracking_table import bstt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_item
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]  state_r;
  in_item_t    item_r;
  content_t    src_r;
  content_t    dst_r;
  logic        src_any_r;
  logic        dst_any_r;
  out_item_t   out_r;
  out_item_t   out_nxt;
  cell_cmd_t   cmd;
  logic        store_op;
  logic        full;

  logic     [TABLE_ENTRIES:0]   free_chain;
  logic     [TABLE_ENTRIES-1:0] dst_m;
  logic     [TABLE_ENTRIES-1:0] src_m;
  content_t [TABLE_ENTRIES-1:0] dst_d;
  content_t [TABLE_ENTRIES-1:0] src_d;
  content_t                     dst_or;
  content_t                     src_or;

  assign free_chain[0] = 1'b0;
  assign full          = !free_chain[TABLE_ENTRIES];

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    bstt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .free_in   (free_chain[g]),
      .free_out  (free_chain[g+1]),
      .dst_match (dst_m[g]),
      .src_match (src_m[g]),
      .dst_data  (dst_d[g]),
      .src_data  (src_d[g])
    );
  end

  always_comb begin
    dst_or = '0;
    src_or = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      dst_or = dst_or | dst_d[i];
      src_or = src_or | src_d[i];
    end
  end

  assign store_op = item_r.operation == OP_SET || (item_r.operation == OP_COPY && src_any_r);

  always_comb begin
    cmd           = '0;
    cmd.owner     = item_r.key_owner;
    cmd.rest      = item_r.key_rest;
    cmd.src_owner = item_r.src_owner;
    cmd.src_rest  = item_r.src_rest;
    cmd.handle    = item_r.content_handle;
    cmd.payload   = item_r.content_payload;
    out_nxt       = '0;
    if (state_r == ST_LOOK) begin
      cmd.look = 1'b1;
    end
    if (state_r == ST_EXEC) begin
      if (item_r.operation == OP_COPY) begin
        cmd.handle  = src_r.handle;
        cmd.payload = src_r.payload;
      end
      case (item_r.operation)
        OP_SET, OP_COPY: begin
          if (store_op) begin
            cmd.wr_dst       = dst_any_r;
            cmd.ins          = !dst_any_r && !full;
            out_nxt.accepted = dst_any_r || !full;
          end else begin
            cmd.clr_dst      = 1'b1;
            out_nxt.accepted = 1'b1;
          end
        end
        OP_ERASE: begin
          cmd.clr_dst      = 1'b1;
          out_nxt.accepted = 1'b1;
        end
        OP_INVAL: begin
          cmd.clr_inv      = 1'b1;
          out_nxt.accepted = 1'b1;
        end
        OP_FIND: begin
          out_nxt.accepted    = 1'b1;
          out_nxt.hit         = dst_any_r;
          out_nxt.hit_handle  = dst_r.handle;
          out_nxt.hit_payload = dst_r.payload;
        end
        default: begin
          out_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: if (in_valid) state_r <= ST_LOOK;
        ST_LOOK: state_r <= ST_EXEC;
        ST_EXEC: state_r <= ST_DONE;
        ST_DONE: if (out_ready) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      item_r <= in_item;
    end
    if (state_r == ST_LOOK) begin
      src_r     <= src_or;
      dst_r     <= dst_or;
      src_any_r <= |src_m;
      dst_any_r <= |dst_m;
    end
    if (state_r == ST_EXEC) begin
      out_r <= out_nxt;
    end
  end

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = state_r == ST_DONE;
  assign out_item  = out_r;

endmodule

`default_nettype wire

// ===== rtl/bstt_cell.sv =====
// ----------------------------------------------------------------------------
// bstt_cell
// One table entry: key compare, masked content read, free-slot chain link.
// ----------------------------------------------------------------------------
`default_nettype none

module bstt_cell import bstt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_cmd_t cmd,
  input  wire logic      free_in,
  output logic           free_out,
  output logic           dst_match,
  output logic           src_match,
  output content_t       dst_data,
  output content_t       src_data
);

  logic        valid_r;
  logic        dst_hit_r;
  logic        inv_hit_r;
  logic [31:0] owner_r;
  logic [31:0] rest_r;
  logic [63:0] handle_r;
  logic [31:0] payload_r;
  logic        inv_cmp;
  logic        first_free;
  logic        valid_nxt;

  assign dst_match  = valid_r && owner_r == cmd.owner && rest_r == cmd.rest;
  assign src_match  = valid_r && owner_r == cmd.src_owner && rest_r == cmd.src_rest;
  assign inv_cmp    = valid_r && owner_r == cmd.owner && handle_r == cmd.handle;
  assign dst_data   = dst_match ? content_t'{handle_r, payload_r} : '0;
  assign src_data   = src_match ? content_t'{handle_r, payload_r} : '0;
  assign first_free = !valid_r && !free_in;
  assign free_out   = free_in || !valid_r;

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.ins && first_free) begin
      valid_nxt = 1'b1;
    end else if ((cmd.clr_dst && dst_hit_r) || (cmd.clr_inv && inv_hit_r)) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      dst_hit_r <= 1'b0;
      inv_hit_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (cmd.look) begin
        dst_hit_r <= dst_match;
        inv_hit_r <= inv_cmp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins && first_free) begin
      owner_r <= cmd.owner;
      rest_r  <= cmd.rest;
    end
    if ((cmd.ins && first_free) || (cmd.wr_dst && dst_hit_r)) begin
      handle_r  <= cmd.handle;
      payload_r <= cmd.payload;
    end
  end

endmodule

`default_nettype wire
